// ===== hdl/sri_pkg.sv =====
// ----------------------------------------------------------------------------
// sri_pkg
// Shared constants, opcode codes, stage payload type and decode helpers for
// the small RISC execute block.
// ----------------------------------------------------------------------------
package sri_pkg;

    localparam int REG_COUNT  = 32;
    localparam int REG_AW     = $clog2(REG_COUNT);
    localparam int DATA_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);

    localparam int WORD_W     = 32;
    localparam int RIDX_W     = 5;
    localparam int MIDX_W     = 10;

    localparam logic [31:0] DATA_BASE = 32'd1024;
    localparam logic [31:0] PAGE_MASK = 32'hF000_0000;
    localparam logic [31:0] JUMP_MASK = 32'h0FFF_FFFF;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_MOVI = 4'd3,
        OP_JEQ  = 4'd4,
        OP_AND  = 4'd5,
        OP_XORI = 4'd6,
        OP_JMP  = 4'd7,
        OP_LSL  = 4'd8,
        OP_LSR  = 4'd9,
        OP_MOVR = 4'd10,
        OP_MOVM = 4'd11
    } opcode_t;

    // Everything the write-back stage needs for one item
    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        load;
        logic        mem_write;
        logic [9:0]  mem_index;
        logic [31:0] mem_value;
        logic        access_fault;
    } exec_t;

    // R-format ops take their second operand from r3, the rest from r1
    function automatic logic is_rfmt(input logic [3:0] op);
        logic res;
        res = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
              (op == OP_AND) || (op == OP_LSL) || (op == OP_LSR);
        return res;
    endfunction

    // R0 and indices past the file read as zero and are never written
    function automatic logic reg_ok(input logic [4:0] idx);
        logic res;
        res = (idx != 5'd0) && ({1'b0, idx} < 6'(REG_COUNT));
        return res;
    endfunction

endpackage

// ===== hdl/sri_instr_if.sv =====
// ----------------------------------------------------------------------------
// sri_instr_if
// Instruction channel: valid/ready handshake carrying one instruction word.
// ----------------------------------------------------------------------------
interface sri_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

// ===== hdl/sri_result_if.sv =====
// ----------------------------------------------------------------------------
// sri_result_if
// Result channel: valid/ready handshake carrying the effects of one item.
// ----------------------------------------------------------------------------
interface sri_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [9:0]  mem_index;
    logic [31:0] mem_value;
    logic        access_fault;

    modport source (output valid, output next_pc, output reg_write, output reg_index,
                    output reg_value, output mem_write, output mem_index,
                    output mem_value, output access_fault, input ready);
    modport sink   (input valid, input next_pc, input reg_write, input reg_index,
                    input reg_value, input mem_write, input mem_index,
                    input mem_value, input access_fault, output ready);
endinterface

// ===== hdl/sri_ram.sv =====
// ----------------------------------------------------------------------------
// sri_ram
// Generic single-write, single-read RAM with registered read data.
// Read is read-first: a read and write to the same address return old data.
// ----------------------------------------------------------------------------
module sri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/small_risc_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// small_risc_instruction_execute
// Executes one 32-bit instruction word per item against a register file,
// program counter and data memory, and reports the effects of each item.
// ----------------------------------------------------------------------------
// Pipeline: register reads are issued as an item is accepted, the execute
// stage computes the result, next PC and store (and issues a load read), and
// the write-back stage merges load data and writes the register file. An item
// can be accepted every cycle; its result passes through the write-back register
// to the output register, and the single execute stage with full forwarding
// (including load data from the data memory port) sets that one-per-cycle
// rate. Any stall on the result channel holds the whole pipeline. The register
// file is two RAM copies (one per read port) with per-entry valid bits; the
// data memory is one RAM that is cleared after reset, one word per cycle, over
// all DATA_WORDS (1024) words, during which instr.ready stays low.
// ----------------------------------------------------------------------------
module small_risc_instruction_execute (
    input  logic                 clk,
    input  logic                 rst_n,
    sri_instr_if.sink            instr,
    sri_result_if.source         result
);

    logic advance;
    logic accept;

    // clearing pass
    logic                        clr_active_reg;
    logic [sri_pkg::DMEM_AW-1:0] clr_cnt_reg;

    // execute stage
    logic        ex_valid_reg;
    logic [31:0] ex_word_reg;

    // write-back stage
    logic            wb_valid_reg;
    sri_pkg::exec_t  wb_reg;
    sri_pkg::exec_t  wb_next;
    sri_pkg::exec_t  wb_out;
    logic [31:0]     wb_final;

    // last register write, covers the read issued at the same edge
    logic        last_valid_reg;
    logic [4:0]  last_idx_reg;
    logic [31:0] last_val_reg;

    logic [sri_pkg::REG_COUNT-1:0] rf_valid_reg;
    logic [31:0]                   pc_reg;
    logic [31:0]                   pc_next;

    logic        out_valid_reg;
    sri_pkg::exec_t out_reg;

    // RAM ports
    logic                        rf_we;
    logic [31:0]                 rf_rdata_a;
    logic [31:0]                 rf_rdata_b;
    logic [sri_pkg::REG_AW-1:0]  rf_raddr_a;
    logic [sri_pkg::REG_AW-1:0]  rf_raddr_b;
    logic                        dm_we;
    logic [sri_pkg::DMEM_AW-1:0] dm_waddr;
    logic [31:0]                 dm_wdata;
    logic [sri_pkg::DMEM_AW-1:0] dm_raddr;
    logic [31:0]                 dm_rdata;

    // execute decode
    logic [3:0]  op;
    logic [4:0]  r1;
    logic [4:0]  r2;
    logic [4:0]  idx_b;
    logic [12:0] shamt;
    logic [31:0] imm;
    logic [31:0] opnd_a;
    logic [31:0] opnd_b;
    logic [31:0] prod;
    logic [31:0] pc1;
    logic [31:0] addr;
    logic [31:0] off;
    logic        in_rng;
    logic        store_ok;

    assign advance     = !out_valid_reg || result.ready;
    assign instr.ready = advance && !clr_active_reg;
    assign accept      = instr.valid && instr.ready;

    // read addresses straight from the incoming word
    always_comb
    begin
        rf_raddr_a = instr.instruction_word[18 +: sri_pkg::REG_AW];
        if (sri_pkg::is_rfmt(instr.instruction_word[31:28]))
        begin
            rf_raddr_b = instr.instruction_word[13 +: sri_pkg::REG_AW];
        end
        else
        begin
            rf_raddr_b = instr.instruction_word[23 +: sri_pkg::REG_AW];
        end
    end

    assign rf_we = advance && wb_valid_reg && wb_reg.reg_write;

    sri_ram #(.WIDTH(32), .DEPTH(sri_pkg::REG_COUNT)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (wb_reg.reg_index[sri_pkg::REG_AW-1:0]),
        .wdata (wb_final),
        .re    (advance),
        .raddr (rf_raddr_a),
        .rdata (rf_rdata_a)
    );

    sri_ram #(.WIDTH(32), .DEPTH(sri_pkg::REG_COUNT)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (wb_reg.reg_index[sri_pkg::REG_AW-1:0]),
        .wdata (wb_final),
        .re    (advance),
        .raddr (rf_raddr_b),
        .rdata (rf_rdata_b)
    );

    assign wb_final = wb_reg.load ? dm_rdata : wb_reg.reg_value;

    always_comb
    begin
        wb_out           = wb_reg;
        wb_out.reg_value = wb_final;
    end

    // decode of the item in execute
    always_comb
    begin
        op    = ex_word_reg[31:28];
        r1    = ex_word_reg[27:23];
        r2    = ex_word_reg[22:18];
        shamt = ex_word_reg[12:0];
        imm   = {{14{ex_word_reg[17]}}, ex_word_reg[17:0]};
        if (sri_pkg::is_rfmt(op))
        begin
            idx_b = ex_word_reg[17:13];
        end
        else
        begin
            idx_b = r1;
        end
    end

    // operand forwarding: write-back stage first, then last write, then RAM
    always_comb
    begin
        if (!sri_pkg::reg_ok(r2))
        begin
            opnd_a = '0;
        end
        else if (wb_valid_reg && wb_reg.reg_write && wb_reg.reg_index == r2)
        begin
            opnd_a = wb_final;
        end
        else if (last_valid_reg && last_idx_reg == r2)
        begin
            opnd_a = last_val_reg;
        end
        else if (rf_valid_reg[r2[sri_pkg::REG_AW-1:0]])
        begin
            opnd_a = rf_rdata_a;
        end
        else
        begin
            opnd_a = '0;
        end
    end

    always_comb
    begin
        if (!sri_pkg::reg_ok(idx_b))
        begin
            opnd_b = '0;
        end
        else if (wb_valid_reg && wb_reg.reg_write && wb_reg.reg_index == idx_b)
        begin
            opnd_b = wb_final;
        end
        else if (last_valid_reg && last_idx_reg == idx_b)
        begin
            opnd_b = last_val_reg;
        end
        else if (rf_valid_reg[idx_b[sri_pkg::REG_AW-1:0]])
        begin
            opnd_b = rf_rdata_b;
        end
        else
        begin
            opnd_b = '0;
        end
    end

    assign prod   = opnd_a * opnd_b;
    assign pc1    = pc_reg + 32'd1;
    assign addr   = opnd_a + imm;
    assign off    = addr - sri_pkg::DATA_BASE;
    assign in_rng = (addr >= sri_pkg::DATA_BASE) && (off < 32'(sri_pkg::DATA_WORDS));

    always_comb
    begin
        pc_next  = pc1;
        wb_next  = '0;
        store_ok = 1'b0;
        unique case (op)
            sri_pkg::OP_ADD:
            begin
                wb_next.reg_write = 1'b1;
                wb_next.reg_value = opnd_a + opnd_b;
            end
            sri_pkg::OP_SUB:
            begin
                wb_next.reg_write = 1'b1;
                wb_next.reg_value = opnd_a - opnd_b;
            end
            sri_pkg::OP_MUL:
            begin
                wb_next.reg_write = 1'b1;
                wb_next.reg_value = prod;
            end
            sri_pkg::OP_MOVI:
            begin
                wb_next.reg_write = 1'b1;
                wb_next.reg_value = imm;
            end
            sri_pkg::OP_JEQ:
            begin
                if (opnd_b == opnd_a)
                begin
                    pc_next = pc1 + imm;
                end
            end
            sri_pkg::OP_AND:
            begin
                wb_next.reg_write = 1'b1;
                wb_next.reg_value = opnd_a & opnd_b;
            end
            sri_pkg::OP_XORI:
            begin
                wb_next.reg_write = 1'b1;
                wb_next.reg_value = opnd_a ^ imm;
            end
            sri_pkg::OP_JMP:
            begin
                pc_next = (pc1 & sri_pkg::PAGE_MASK) | (ex_word_reg & sri_pkg::JUMP_MASK);
            end
            sri_pkg::OP_LSL:
            begin
                wb_next.reg_write = 1'b1;
                wb_next.reg_value = (shamt >= 13'd32) ? 32'd0 : (opnd_a << shamt[4:0]);
            end
            sri_pkg::OP_LSR:
            begin
                wb_next.reg_write = 1'b1;
                wb_next.reg_value = (shamt >= 13'd32) ? 32'd0 : (opnd_a >> shamt[4:0]);
            end
            sri_pkg::OP_MOVR:
            begin
                wb_next.reg_write = 1'b1;
                if (in_rng)
                begin
                    wb_next.load = 1'b1;
                end
                else
                begin
                    // faulting load writes its own address
                    wb_next.reg_value    = addr;
                    wb_next.access_fault = 1'b1;
                end
            end
            sri_pkg::OP_MOVM:
            begin
                if (in_rng)
                begin
                    store_ok          = 1'b1;
                    wb_next.mem_write = 1'b1;
                    wb_next.mem_index = off[9:0];
                    wb_next.mem_value = opnd_b;
                end
                else
                begin
                    wb_next.access_fault = 1'b1;
                end
            end
            default:
            begin
                // unused opcodes only advance the PC
            end
        endcase
        if (!sri_pkg::reg_ok(r1))
        begin
            wb_next.reg_write = 1'b0;
        end
        if (wb_next.reg_write)
        begin
            wb_next.reg_index = r1;
        end
        else
        begin
            wb_next.reg_value = '0;
            wb_next.load      = 1'b0;
        end
        wb_next.next_pc = pc_next;
    end

    // data memory: clearing pass owns the write port after reset
    always_comb
    begin
        if (clr_active_reg)
        begin
            dm_we    = 1'b1;
            dm_waddr = clr_cnt_reg;
            dm_wdata = '0;
        end
        else
        begin
            dm_we    = advance && ex_valid_reg && store_ok;
            dm_waddr = off[sri_pkg::DMEM_AW-1:0];
            dm_wdata = opnd_b;
        end
        dm_raddr = off[sri_pkg::DMEM_AW-1:0];
    end

    sri_ram #(.WIDTH(32), .DEPTH(sri_pkg::DATA_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (advance),
        .raddr (dm_raddr),
        .rdata (dm_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            ex_valid_reg   <= 1'b0;
            wb_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_valid_reg <= 1'b0;
            rf_valid_reg   <= '0;
            pc_reg         <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == sri_pkg::DMEM_AW'(sri_pkg::DATA_WORDS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (advance)
            begin
                ex_valid_reg   <= accept;
                wb_valid_reg   <= ex_valid_reg;
                out_valid_reg  <= wb_valid_reg;
                last_valid_reg <= rf_we;
                if (ex_valid_reg)
                begin
                    pc_reg <= pc_next;
                end
            end
            if (rf_we)
            begin
                rf_valid_reg[wb_reg.reg_index[sri_pkg::REG_AW-1:0]] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ex_word_reg  <= instr.instruction_word;
            wb_reg       <= wb_next;
            last_idx_reg <= wb_reg.reg_index;
            last_val_reg <= wb_final;
            out_reg      <= wb_out;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.next_pc      = out_reg.next_pc;
    assign result.reg_write    = out_reg.reg_write;
    assign result.reg_index    = out_reg.reg_index;
    assign result.reg_value    = out_reg.reg_value;
    assign result.mem_write    = out_reg.mem_write;
    assign result.mem_index    = out_reg.mem_index;
    assign result.mem_value    = out_reg.mem_value;
    assign result.access_fault = out_reg.access_fault;

endmodule

// ===== tb/sv/small_risc_instruction_execute_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_risc_instruction_execute_tb
// Self-checking bench for the RISC execute block. A shadow copy of the
// register file, PC and data memory predicts the effects of each accepted
// instruction item. A checker compares every result item field by field
// against the oldest prediction. Directed programs cover each opcode and the
// corner cases. Random programs with random idling on both channels follow,
// then a full-rate stretch and a long output stall.
// ----------------------------------------------------------------------------
module small_risc_instruction_execute_tb;

    // Opcodes outside the enum execute as no-ops
    localparam logic [3:0] OP_SPARE_LO = 4'd12;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    localparam int IDLE_PCT    = 31;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [9:0]  mem_index;
        logic [31:0] mem_value;
        logic        access_fault;
    } effects_t;

    logic clk;
    logic rst_n;

    sri_instr_if  instr_ch ();
    sri_result_if result_ch ();

    small_risc_instruction_execute i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    // Shadow architectural state
    logic [31:0] gpr_shadow [sri_pkg::REG_COUNT];
    logic [31:0] pc_shadow;
    logic [31:0] dmem_shadow [sri_pkg::DATA_WORDS];

    effects_t pending_fx_q [$];

    int  errors          = 0;
    int  items_sent;
    int  results_checked = 0;
    int  faults_seen     = 0;
    int  stores_seen     = 0;
    int  hold_requests   = 0;
    bit  full_rate;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("%0t: timeout, %0d results still pending", $time, pending_fx_q.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] read_gpr(input logic [4:0] idx);
        if (idx == 5'd0 || int'(idx) >= sri_pkg::REG_COUNT)
            return 32'd0;
        return gpr_shadow[idx];
    endfunction

    function automatic bit in_data_region(input logic [31:0] addr);
        return addr >= sri_pkg::DATA_BASE &&
               (addr - sri_pkg::DATA_BASE) < 32'(sri_pkg::DATA_WORDS);
    endfunction

    task automatic execute_instr(input logic [31:0] w);
        logic [3:0]  op;
        logic [4:0]  r1;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc1;
        logic [31:0] addr;
        logic [31:0] off;
        logic [sri_pkg::DMEM_AW-1:0] widx;
        logic [31:0] val;
        logic [12:0] shamt;
        bit          wb;
        effects_t    fx;
        op    = w[31:28];
        r1    = w[27:23];
        shamt = w[12:0];
        imm   = {{14{w[17]}}, w[17:0]};
        a     = read_gpr(w[22:18]);
        b     = read_gpr(w[17:13]);
        pc1   = pc_shadow + 32'd1;
        fx    = '0;
        fx.next_pc = pc1;
        wb    = 1'b0;
        val   = 32'd0;
        unique case (op)
            sri_pkg::OP_ADD:  begin wb = 1'b1; val = a + b; end
            sri_pkg::OP_SUB:  begin wb = 1'b1; val = a - b; end
            sri_pkg::OP_MUL:  begin wb = 1'b1; val = a * b; end
            sri_pkg::OP_MOVI: begin wb = 1'b1; val = imm; end
            sri_pkg::OP_AND:  begin wb = 1'b1; val = a & b; end
            sri_pkg::OP_XORI: begin wb = 1'b1; val = a ^ imm; end
            sri_pkg::OP_LSL:
            begin
                wb  = 1'b1;
                val = (shamt >= 13'd32) ? 32'd0 : a << shamt;
            end
            sri_pkg::OP_LSR:
            begin
                wb  = 1'b1;
                val = (shamt >= 13'd32) ? 32'd0 : a >> shamt;
            end
            sri_pkg::OP_JEQ:
            begin
                if (read_gpr(r1) == a)
                    fx.next_pc = pc1 + imm;
            end
            sri_pkg::OP_JMP:
                fx.next_pc = (pc1 & sri_pkg::PAGE_MASK) | (w & sri_pkg::JUMP_MASK);
            sri_pkg::OP_MOVR:
            begin
                wb   = 1'b1;
                addr = a + imm;
                off  = addr - sri_pkg::DATA_BASE;
                widx = off[sri_pkg::DMEM_AW-1:0];
                if (in_data_region(addr))
                    val = dmem_shadow[widx];
                else
                begin
                    // faulting load returns its own address
                    val = addr;
                    fx.access_fault = 1'b1;
                end
            end
            sri_pkg::OP_MOVM:
            begin
                addr = a + imm;
                off  = addr - sri_pkg::DATA_BASE;
                widx = off[sri_pkg::DMEM_AW-1:0];
                if (in_data_region(addr))
                begin
                    fx.mem_write = 1'b1;
                    fx.mem_index = off[9:0];
                    fx.mem_value = read_gpr(r1);
                    dmem_shadow[widx] = fx.mem_value;
                end
                else
                    fx.access_fault = 1'b1;
            end
            default: ;
        endcase
        if (wb && r1 != 5'd0 && int'(r1) < sri_pkg::REG_COUNT)
        begin
            gpr_shadow[r1] = val;
            fx.reg_write   = 1'b1;
            fx.reg_index   = r1;
            fx.reg_value   = val;
        end
        pc_shadow = fx.next_pc;
        pending_fx_q.push_back(fx);
    endtask

    // ------------------------------------------------------------------
    // Encoding and random program generation
    // ------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input logic [3:0] op, input logic [4:0] d,
                                          input logic [4:0] s, input logic [4:0] t,
                                          input logic [12:0] sh);
        return {op, d, s, t, sh};
    endfunction

    function automatic logic [31:0] enc_i(input logic [3:0] op, input logic [4:0] d,
                                          input logic [4:0] s, input logic [17:0] imm);
        return {op, d, s, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [27:0] target);
        return {sri_pkg::OP_JMP, target};
    endfunction

    // Mostly a few low registers so back-to-back items depend on each other
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(99) < 70)
            return 5'($urandom_range(7));
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [31:0] random_instr();
        logic [3:0]  op;
        logic [4:0]  r1;
        logic [4:0]  r2;
        logic [4:0]  r3;
        logic [17:0] imm;
        logic [12:0] shamt;
        logic [31:0] target;
        logic [31:0] offs;
        logic [31:0] raw;
        raw = $urandom();
        // some pure noise
        if ($urandom_range(99) < 12)
            return raw;
        op    = 4'($urandom_range(15));
        r1    = pick_reg();
        r2    = pick_reg();
        r3    = pick_reg();
        imm   = 18'($urandom());
        shamt = $urandom_range(1) ? 13'($urandom_range(31)) : 13'($urandom());
        case (op)
            sri_pkg::OP_MOVI:
            begin
                // seed registers with data addresses
                if ($urandom_range(99) < 30)
                    imm = 18'(sri_pkg::DATA_BASE +
                              $urandom_range(sri_pkg::DATA_WORDS - 1));
            end
            sri_pkg::OP_MOVR, sri_pkg::OP_MOVM:
            begin
                if ($urandom_range(99) < 80)
                begin
                    // hit a small hot set often so loads see earlier stores
                    target = sri_pkg::DATA_BASE +
                             ($urandom_range(1) ? $urandom_range(15)
                                                : $urandom_range(sri_pkg::DATA_WORDS - 1));
                    offs   = target - read_gpr(r2);
                    if ($signed(offs) >= -131072 && $signed(offs) <= 131071)
                        imm = offs[17:0];
                    else
                    begin
                        r2  = 5'd0;
                        imm = target[17:0];
                    end
                end
            end
            sri_pkg::OP_JEQ:
            begin
                if ($urandom_range(1))
                    r2 = r1;
            end
            default: ;
        endcase
        case (op)
            sri_pkg::OP_ADD, sri_pkg::OP_SUB, sri_pkg::OP_MUL, sri_pkg::OP_AND,
            sri_pkg::OP_LSL, sri_pkg::OP_LSR:
                return enc_r(op, r1, r2, r3, shamt);
            sri_pkg::OP_JMP:
                return enc_j(raw[27:0]);
            default:
                return enc_i(op, r1, r2, imm);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver, receiver, checker
    // ------------------------------------------------------------------
    // Called and returns at a falling edge; valid stays up between items unless an idle gap is drawn
    task automatic send_instr(input logic [31:0] word);
        while (!full_rate && $urandom_range(99) < IDLE_PCT)
        begin
            instr_ch.valid <= 1'b0;
            @(negedge clk);
        end
        instr_ch.valid            <= 1'b1;
        instr_ch.instruction_word <= word;
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
        execute_instr(word);
        items_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (full_rate)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        effects_t got;
        effects_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = {result_ch.next_pc, result_ch.reg_write, result_ch.reg_index,
                   result_ch.reg_value, result_ch.mem_write, result_ch.mem_index,
                   result_ch.mem_value, result_ch.access_fault};
            if (pending_fx_q.size() == 0)
            begin
                $display("%0t: result with nothing pending, expected none, actual next_pc %h",
                         $time, got.next_pc);
                errors++;
            end
            else
            begin
                want = pending_fx_q.pop_front();
                results_checked++;
                faults_seen    += int'(want.access_fault);
                stores_seen    += int'(want.mem_write);
                check_field("next_pc", want.next_pc, got.next_pc);
                check_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
                check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
                check_field("reg_value", want.reg_value, got.reg_value);
                check_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
                check_field("mem_index", 32'(want.mem_index), 32'(got.mem_index));
                check_field("mem_value", want.mem_value, got.mem_value);
                check_field("access_fault", 32'(want.access_fault),
                            32'(got.access_fault));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_alu_ops();
        send_instr(enc_i(sri_pkg::OP_MOVI, 5'd1, 5'd0, 18'h1FFFF));
        send_instr(enc_i(sri_pkg::OP_MOVI, 5'd2, 5'd0, 18'h20000));
        send_instr(enc_i(sri_pkg::OP_MOVI, 5'd31, 5'd0, 18'h3FFFF));
        // writes to R0 are dropped
        send_instr(enc_i(sri_pkg::OP_MOVI, 5'd0, 5'd0, 18'h00005));
        send_instr(enc_r(sri_pkg::OP_ADD, 5'd3, 5'd1, 5'd31, 13'd0));
        send_instr(enc_r(sri_pkg::OP_SUB, 5'd4, 5'd2, 5'd1, 13'd0));
        send_instr(enc_r(sri_pkg::OP_MUL, 5'd5, 5'd31, 5'd2, 13'd0));
        send_instr(enc_r(sri_pkg::OP_AND, 5'd6, 5'd31, 5'd1, 13'd0));
        send_instr(enc_r(sri_pkg::OP_ADD, 5'd0, 5'd1, 5'd1, 13'd0));
        send_instr(enc_i(sri_pkg::OP_XORI, 5'd11, 5'd1, 18'h3FFFF));
    endtask

    task automatic test_shifts();
        send_instr(enc_r(sri_pkg::OP_LSL, 5'd7, 5'd31, 5'd0, 13'd0));
        send_instr(enc_r(sri_pkg::OP_LSL, 5'd8, 5'd31, 5'd0, 13'd31));
        send_instr(enc_r(sri_pkg::OP_LSR, 5'd9, 5'd31, 5'd0, 13'd32));
        send_instr(enc_r(sri_pkg::OP_LSR, 5'd10, 5'd2, 5'd31, 13'h1FFF));
    endtask

    task automatic test_memory();
        send_instr(enc_i(sri_pkg::OP_MOVI, 5'd12, 5'd0, 18'(sri_pkg::DATA_BASE)));
        send_instr(enc_i(sri_pkg::OP_MOVM, 5'd31, 5'd12, 18'(sri_pkg::DATA_WORDS - 1)));
        send_instr(enc_i(sri_pkg::OP_MOVR, 5'd13, 5'd12, 18'(sri_pkg::DATA_WORDS - 1)));
        send_instr(enc_i(sri_pkg::OP_MOVM, 5'd1, 5'd12, 18'd0));
        // just below and just above the data region
        send_instr(enc_i(sri_pkg::OP_MOVM, 5'd1, 5'd12, 18'h3FFFF));
        send_instr(enc_i(sri_pkg::OP_MOVR, 5'd14, 5'd12, 18'(sri_pkg::DATA_WORDS)));
    endtask

    task automatic test_control_flow();
        send_instr(enc_i(sri_pkg::OP_JEQ, 5'd1, 5'd1, 18'd5));
        send_instr(enc_i(sri_pkg::OP_JEQ, 5'd1, 5'd2, 18'h3FFFD));
        send_instr(enc_i(sri_pkg::OP_JEQ, 5'd0, 5'd0, 18'h20000));
        send_instr(enc_j(28'hFFF_FFFF));
        send_instr(enc_j(28'h000_0000));
        send_instr({OP_SPARE_LO, 28'hFFF_FFFF});
        send_instr({OP_SPARE_HI, 28'h000_0000});
    endtask

    task automatic test_random_program(input int count);
        repeat (count)
            send_instr(random_instr());
    endtask

    task automatic test_full_rate(input int count);
        full_rate = 1'b1;
        test_random_program(count);
        full_rate = 1'b0;
    endtask

    // Sink stalls for a long stretch while the source keeps offering items
    task automatic test_backpressure(input int count);
        hold_requests++;
        test_random_program(count);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        items_sent      = 0;
        full_rate       = 1'b0;
        pc_shadow       = 32'd0;
        foreach (gpr_shadow[i])
            gpr_shadow[i] = 32'd0;
        foreach (dmem_shadow[i])
            dmem_shadow[i] = 32'd0;

        rst_n                     = 1'b0;
        instr_ch.valid            = 1'b0;
        instr_ch.instruction_word = 32'd0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_alu_ops();
        test_shifts();
        test_memory();
        test_control_flow();
        test_random_program(450);
        test_full_rate(150);
        test_backpressure(80);
        instr_ch.valid <= 1'b0;

        while (pending_fx_q.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        $display("Ran %0d instruction items, %0d results checked, %0d errors.",
                 items_sent, results_checked, errors);
        $display("Stores seen: %0d, access faults seen: %0d.", stores_seen, faults_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== small_risc_instruction_execute.f =====
hdl/sri_pkg.sv
hdl/sri_instr_if.sv
hdl/sri_result_if.sv
hdl/sri_ram.sv
hdl/small_risc_instruction_execute.sv
tb/sv/small_risc_instruction_execute_tb.sv
